FILE: hw/rtl/tpc_pkg.sv
// Shared types and constants for the timed TTL pattern compiler.
// Used by the controller, the datapath and the top level; depends on nothing.
package tpc_pkg;

  // Field widths of one stored command.
  localparam int TIME_W  = 32;
  localparam int BANK_W  = 2;
  localparam int BITP_W  = 4;
  localparam int ENTRY_W = TIME_W + BANK_W + BITP_W + 1;
  localparam int LINES   = 64;
  localparam int WORD_W  = 16;

  // Stream payload widths.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 96;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam logic [0:0] REG_INITIAL_LINES = 1'b0;

  // Snapshot time divisor, held at the width of a low-plus-high sum.
  localparam logic [16:0] TIME_DIV   = 17'd65535;
  localparam logic [16:0] TIME_DIV_2 = 17'd131070;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_EMIT
  } tpc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_wr;
    logic seed;
    logic rd_issue;
    logic eval;
    logic emit_load;
    logic next_group;
    logic clear;
  } tpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic out_free;
    logic found;
  } tpc_status_t;

endpackage

FILE: hw/rtl/timed_ttl_pattern_compiler_top.sv
// Top level of the timed TTL pattern compiler: configuration register,
// controller and datapath. Depends on tpc_pkg, tpc_ctrl and tpc_datapath.
//
//   Channel  Direction  Transaction
//   in_      slave      one timed line command; tlast marks the final one
//   out_     master     one snapshot of 64 lines; tlast marks the last one
//   cfg_     APB slave  initial_lines at byte address 0 (64 bits)
//
// Commands load at one per cycle. After the final command the block stops
// taking commands and emits snapshots: each snapshot costs one sweep of the
// command memory, a registered read and then an evaluate step per stored
// entry, plus a step that finds the sweep done and one that loads the
// output register. A stalled output holds the sweep before the next group.
// Reset is synchronous and empties the store; memory contents need no reset.
module timed_ttl_pattern_compiler_top #(
  parameter int MAX_COMMANDS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Fields from bit 0: event_time[31:0], bank[33:32], bit_position[37:34],
  // level[38], zero pad[39].
  input  logic [tpc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tlast,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: time_low[15:0], time_high[31:16], bank_a_word[47:32],
  // bank_b_word[63:48], bank_c_word[79:64], bank_d_word[95:80].
  output logic [tpc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tpc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [tpc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import tpc_pkg::*;

  tpc_cmd_t          cmd;
  tpc_status_t       status;
  logic [LINES-1:0]  initial_lines_r;
  logic [ENTRY_W-1:0] in_entry;
  logic              reg_sel;

  // Configuration register; the register index is paddr / 8.
  assign reg_sel    = (cfg_paddr[3] == REG_INITIAL_LINES);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? initial_lines_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_lines_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      initial_lines_r <= cfg_pwdata;
    end
  end

  // Stored entry layout: time, bank, bit, level from the top bit down.
  assign in_entry = {in_tdata[31:0], in_tdata[33:32], in_tdata[37:34], in_tdata[38]};

  tpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tpc_datapath #(
    .MAX_COMMANDS (MAX_COMMANDS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_entry      (in_entry),
    .initial_lines (initial_lines_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule

FILE: hw/rtl/tpc_ctrl.sv
// Controller state machine of the timed TTL pattern compiler.
// Depends on tpc_pkg; drives the datapath through tpc_cmd_t only.
module tpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tlast,
  output logic                 in_tready,
  input  tpc_pkg::tpc_status_t status,
  output tpc_pkg::tpc_cmd_t    cmd
);
  import tpc_pkg::*;

  tpc_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tlast) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = status.sweep_done ? S_EMIT : S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_READ;
      end
      S_EMIT: begin
        if (status.out_free) state_nxt = status.found ? S_READ : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.store_wr = in_tvalid;
        cmd.seed     = in_tvalid && in_tlast;
      end
      S_READ: begin
        cmd.rd_issue = !status.sweep_done;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
      end
      S_EMIT: begin
        cmd.emit_load  = status.out_free;
        cmd.next_group = status.out_free && status.found;
        cmd.clear      = status.out_free && !status.found;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/tpc_datapath.sv
// Datapath of the timed TTL pattern compiler: command memory, group sweep,
// line levels and the snapshot output register. Depends on tpc_pkg.
module tpc_datapath #(
  parameter int MAX_COMMANDS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tpc_pkg::tpc_cmd_t               cmd,
  output tpc_pkg::tpc_status_t            status,
  input  logic [tpc_pkg::ENTRY_W-1:0]     in_entry,
  input  logic [tpc_pkg::LINES-1:0]       initial_lines,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tpc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast
);
  import tpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_COMMANDS + 1);
  localparam int IDX_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COMMANDS);

  logic [ENTRY_W-1:0]      mem [MAX_COMMANDS];
  logic [ENTRY_W-1:0]      rd_data_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [MAX_COMMANDS-1:0] consumed_r, consumed_nxt;
  logic [LINES-1:0]        levels_r, levels_nxt;
  logic [TIME_W-1:0]       cur_t_r, cur_t_nxt;
  logic [TIME_W-1:0]       best_r, best_nxt;
  logic                    found_r, found_nxt;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_last_r;

  logic                    full;
  logic [IDX_W-1:0]        rd_idx;
  logic [TIME_W-1:0]       e_time;
  logic [5:0]              e_line;
  logic                    e_used, e_hit, e_cand;
  logic [16:0]             t_sum;
  logic [15:0]             t_low, t_high;

  assign full   = (cnt_r == CNT_MAX);
  assign rd_idx = idx_r[IDX_W-1:0];

  // Command memory: one write port while loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store_wr && !full) begin
      mem[cnt_r[IDX_W-1:0]] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Fields of the entry under evaluation.
  assign e_time = rd_data_r[ENTRY_W-1 -: TIME_W];
  assign e_line = rd_data_r[6:1];
  assign e_used = consumed_r[rd_idx];
  assign e_hit  = !e_used && (e_time == cur_t_r);
  assign e_cand = !e_used && !e_hit;

  // Sweep, group apply and minimum search.
  always_comb begin
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    consumed_nxt = consumed_r;
    levels_nxt   = levels_r;
    cur_t_nxt    = cur_t_r;
    best_nxt     = best_r;
    found_nxt    = found_r;
    if (cmd.store_wr && !full) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.seed) begin
      idx_nxt      = '0;
      consumed_nxt = '0;
      levels_nxt   = initial_lines;
      cur_t_nxt    = '0;
      best_nxt     = '0;
      found_nxt    = 1'b0;
    end
    if (cmd.eval) begin
      idx_nxt = idx_r + CNT_W'(1);
      if (e_hit) begin
        levels_nxt[e_line]   = rd_data_r[0];
        consumed_nxt[rd_idx] = 1'b1;
      end
      if (e_cand && (!found_r || (e_time < best_r))) begin
        best_nxt  = e_time;
        found_nxt = 1'b1;
      end
    end
    if (cmd.next_group) begin
      cur_t_nxt = best_r;
      found_nxt = 1'b0;
      idx_nxt   = '0;
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    idx_r      <= idx_nxt;
    consumed_r <= consumed_nxt;
    levels_r   <= levels_nxt;
    cur_t_r    <= cur_t_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
  end

  // Time split by 65535: t = h*65536 + l = h*65535 + (h + l).
  assign t_sum = {1'b0, cur_t_r[31:16]} + {1'b0, cur_t_r[15:0]};
  always_comb begin
    priority if (t_sum == TIME_DIV_2) begin
      t_low  = '0;
      t_high = cur_t_r[31:16] + 16'd2;
    end else if (t_sum >= TIME_DIV) begin
      t_low  = 16'(t_sum - TIME_DIV);
      t_high = cur_t_r[31:16] + 16'd1;
    end else begin
      t_low  = t_sum[15:0];
      t_high = cur_t_r[31:16];
    end
  end

  // Snapshot output register; it holds until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data_r <= {levels_r, t_high, t_low};
      out_last_r <= !found_r;
    end
  end

  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_data_r;
  assign out_tlast         = out_last_r;
  assign status.sweep_done = (idx_r == cnt_r);
  assign status.out_free   = !out_valid_r || out_tready;
  assign status.found      = found_r;

endmodule

FILE: bench/tb_timed_ttl_pattern_compiler_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for timed_ttl_pattern_compiler_top: streams timed line commands
// and checks each emitted snapshot against a local model. Depends on tpc_pkg and the top.
module tb_timed_ttl_pattern_compiler_top;
  import tpc_pkg::*;

  localparam int MAX_COMMANDS = 32;
  localparam int unsigned TIME_DIVISOR = 65535;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 20;
  localparam int UNUSED_REG_INDEX = 1;
  localparam logic [CFG_ADDR_W-1:0] INITIAL_LINES_ADDR = CFG_ADDR_W'(REG_INITIAL_LINES * 8);
  localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_ADDR = CFG_ADDR_W'(UNUSED_REG_INDEX * 8);

  typedef struct packed {
    logic [31:0] event_time;
    logic [1:0]  bank;
    logic [3:0]  bit_position;
    logic        level;
  } line_cmd_t;

  typedef struct packed {
    logic [15:0] bank_d_word;
    logic [15:0] bank_c_word;
    logic [15:0] bank_b_word;
    logic [15:0] bank_a_word;
    logic [15:0] time_high;
    logic [15:0] time_low;
    logic        final_snapshot;
  } snapshot_t;

  // Holds the loaded commands and the snapshots that the block still owes.
  class snapshot_scoreboard;
    logic [63:0] initial_lines;
    line_cmd_t   loaded_commands[$];
    snapshot_t   pending_snapshots[$];
    int          errors;

    function new();
      initial_lines = '0;
      errors = 0;
    endfunction

    // Store one command; the final one compiles the whole timeline.
    function void note_command(line_cmd_t cmd, logic is_final);
      logic [63:0] levels;
      bit [31:0]   consumed;
      int unsigned now_time;
      int unsigned next_time;
      bit          found;
      snapshot_t   snap;
      if (loaded_commands.size() < MAX_COMMANDS) loaded_commands = {loaded_commands, cmd};
      if (!is_final) return;
      levels = initial_lines;
      consumed = '0;
      now_time = 0;
      found = 1'b1;
      while (found) begin
        // Apply the group in load order so the later command for a line wins.
        foreach (loaded_commands[i]) begin
          if (!consumed[i] && loaded_commands[i].event_time == now_time) begin
            levels[{loaded_commands[i].bank, loaded_commands[i].bit_position}] =
              loaded_commands[i].level;
            consumed[i] = 1'b1;
          end
        end
        snap.time_low = 16'(now_time % TIME_DIVISOR);
        snap.time_high = 16'(now_time / TIME_DIVISOR);
        snap.bank_a_word = levels[15:0];
        snap.bank_b_word = levels[31:16];
        snap.bank_c_word = levels[47:32];
        snap.bank_d_word = levels[63:48];
        // Find the earliest time that is still outstanding.
        found = 1'b0;
        next_time = 0;
        foreach (loaded_commands[i]) begin
          if (!consumed[i] && (!found || loaded_commands[i].event_time < next_time)) begin
            next_time = loaded_commands[i].event_time;
            found = 1'b1;
          end
        end
        snap.final_snapshot = !found;
        pending_snapshots = {pending_snapshots, snap};
        now_time = next_time;
      end
      loaded_commands.delete();
    endfunction

    function void report_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: snapshot %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted snapshot with the oldest one owed.
    function void check_snapshot(logic [OUT_DATA_W-1:0] data, logic last);
      snapshot_t got;
      snapshot_t want;
      got = {data, last};
      if (pending_snapshots.size() == 0) begin
        $display("%0t: unexpected snapshot, expected none, actual %h last %b",
                 $time, data, last);
        errors++;
        return;
      end
      want = pending_snapshots.pop_front();
      report_field("time_low", want.time_low, got.time_low);
      report_field("time_high", want.time_high, got.time_high);
      report_field("bank_a_word", want.bank_a_word, got.bank_a_word);
      report_field("bank_b_word", want.bank_b_word, got.bank_b_word);
      report_field("bank_c_word", want.bank_c_word, got.bank_c_word);
      report_field("bank_d_word", want.bank_d_word, got.bank_d_word);
      report_field("final_snapshot", 16'(want.final_snapshot), 16'(got.final_snapshot));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  snapshot_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  timed_ttl_pattern_compiler_top #(.MAX_COMMANDS(MAX_COMMANDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, random stalls otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitors for accepted transactions on both streams.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_command(line_cmd_t'({in_tdata[31:0], in_tdata[33:32], in_tdata[37:34],
                                   in_tdata[38]}), in_tlast);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_snapshot(out_tdata, out_tlast);
    end
  end

  // One APB transfer: setup cycle, then access until pready.
  task automatic reg_access(input bit is_write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= is_write;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write initial_lines, poke the unused slot, and read the register back.
  task automatic program_initial_lines(input logic [63:0] value);
    logic [CFG_DATA_W-1:0] readback;
    reg_access(1'b1, INITIAL_LINES_ADDR, value, readback);
    sb.initial_lines = value;
    reg_access(1'b1, UNUSED_REG_ADDR, ~value, readback);
    reg_access(1'b0, INITIAL_LINES_ADDR, '0, readback);
    if (readback !== value) begin
      $display("%0t: initial_lines readback mismatch, expected %h, actual %h",
               $time, value, readback);
      sb.errors++;
    end
  endtask

  // Offer one command and wait until it is accepted.
  task automatic send_command(input logic [31:0] event_time, input logic [1:0] bank,
                              input logic [3:0] bit_position, input logic level,
                              input logic is_final);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, level, bit_position, bank, event_time};
    in_tlast <= is_final;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // Mostly a few shared small times so groups form, plus divisor edges and wide values.
  function automatic logic [31:0] pick_event_time();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) return $urandom_range(0, 6);
    if (kind < 8) return $urandom_range(1, 65536) * TIME_DIVISOR + $urandom_range(0, 2) - 1;
    return $urandom;
  endfunction

  // One random load ending in a final command; now and then it overflows the store.
  task automatic send_random_load(output int count);
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 10);
    for (int i = 0; i < count; i++) begin
      send_command(pick_event_time(), 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), i == count - 1);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every owed snapshot has arrived and the block has settled.
  task automatic drain();
    @(posedge clk);
    while (sb.pending_snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sent;
    int count;
    logic [63:0] phase_lines[4];
    int phase_idle[4];
    int phase_stall[4];

    phase_lines = '{$urandom, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_3333_CCCC, 64'h0};
    phase_idle = '{0, 49, 0, 37};
    phase_stall = '{0, 0, 49, 37};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: lines cleared, lone final command at time zero on the top line.
    program_initial_lines(64'h0);
    send_command(32'd0, 2'd3, 4'd15, 1'b1, 1'b1);
    in_tvalid <= 1'b0;
    drain();

    // Directed: divisor boundaries, widest times, and a line overwritten within one time.
    send_command(32'hFFFF_FFFF, 2'd0, 4'd0, 1'b1, 1'b0);
    send_command(32'd65535, 2'd1, 4'd7, 1'b1, 1'b0);
    send_command(32'd65534, 2'd2, 4'd8, 1'b1, 1'b0);
    send_command(32'd65535, 2'd1, 4'd7, 1'b0, 1'b0);
    send_command(32'd65536, 2'd3, 4'd0, 1'b1, 1'b0);
    send_command(32'd131070, 2'd0, 4'd15, 1'b1, 1'b0);
    send_command(32'd0, 2'd1, 4'd0, 1'b1, 1'b0);
    send_command(32'd4294901759, 2'd2, 4'd3, 1'b1, 1'b1);
    in_tvalid <= 1'b0;
    drain();

    // Directed: all lines high, turned off and on repeatedly at one time.
    program_initial_lines(64'hFFFF_FFFF_FFFF_FFFF);
    send_command(32'd5, 2'd0, 4'd0, 1'b0, 1'b0);
    send_command(32'd5, 2'd0, 4'd0, 1'b1, 1'b0);
    send_command(32'd5, 2'd0, 4'd0, 1'b0, 1'b0);
    send_command(32'd3, 2'd3, 4'd15, 1'b0, 1'b0);
    send_command(32'd3, 2'd2, 4'd9, 1'b0, 1'b0);
    send_command(32'd0, 2'd3, 4'd15, 1'b0, 1'b1);
    in_tvalid <= 1'b0;
    drain();

    // Random loads under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      program_initial_lines(phase_lines[p]);
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_load(count);
        sent += count;
      end
      drain();
    end

    // Receiver holds off while two loads are offered back to back.
    program_initial_lines({$urandom, $urandom});
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    send_random_load(count);
    send_random_load(count);
    drain();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: timed_ttl_pattern_compiler_top.f
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_ctrl.sv
hw/rtl/tpc_datapath.sv
hw/rtl/timed_ttl_pattern_compiler_top.sv
bench/tb_timed_ttl_pattern_compiler_top.sv
